FILE: hdl/btc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types, constants and helpers for the bit-matrix closure core.
// ----------------------------------------------------------------------------
package btc_pkg;

  localparam int MAX_EVENTS = 64;
  localparam int ROW_W      = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int ACT_W      = 2;
  localparam int REG_IDX_W  = 2;
  localparam int CFG_W      = 7;
  localparam int OUT_DEPTH  = 4;
  localparam int OCC_W      = $clog2(OUT_DEPTH + 1);
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_N_EVENTS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_REFLEXIVE = 2'd1;

  typedef struct packed {
    logic [CNT_W-1:0] n_use;
    logic [ROW_W-1:0] mask;
    logic             reflexive;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
    logic [CNT_W-1:0] successor_count;
    logic             closure_done;
  } result_t;

  function automatic logic [ROW_W-1:0] col_mask(input logic [CNT_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int j = 0; j < ROW_W; j++) begin
      m[j] = (CNT_W'(j) < n);
    end
    return m;
  endfunction

  // count each byte, then add the byte counts as a balanced tree
  function automatic logic [CNT_W-1:0] pop_count(input logic [ROW_W-1:0] v);
    logic [3:0]       byte_cnt [8];
    logic [CNT_W-1:0] c;
    for (int k = 0; k < 8; k++) begin
      byte_cnt[k] = '0;
      for (int j = 0; j < 8; j++) begin
        byte_cnt[k] = byte_cnt[k] + 4'(v[8*k+j]);
      end
    end
    c = ((CNT_W'(byte_cnt[0]) + CNT_W'(byte_cnt[1])) +
         (CNT_W'(byte_cnt[2]) + CNT_W'(byte_cnt[3]))) +
        ((CNT_W'(byte_cnt[4]) + CNT_W'(byte_cnt[5])) +
         (CNT_W'(byte_cnt[6]) + CNT_W'(byte_cnt[7])));
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/btc_row_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_row_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module btc_row_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/btc_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_out_fifo
// Small result queue between the engine and the master stream.
// ----------------------------------------------------------------------------
module btc_out_fifo (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  btc_pkg::result_t             push_data,
  input  wire logic                    pop,
  output logic                         not_empty,
  output btc_pkg::result_t             head,
  output logic [btc_pkg::OCC_W-1:0]    occ
);
  import btc_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);

  result_t          entries [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign not_empty = (occ != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      occ <= occ + OCC_W'(push) - OCC_W'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from empty result queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (occ != OCC_W'(OUT_DEPTH)))
    else $error("push into full result queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (occ == $past(occ) + OCC_W'(1)))
    else $error("occupancy did not advance on push");

endmodule
`default_nettype wire

FILE: hdl/btc_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_engine
// Row access and closure sequencer around the row RAM, with write forwarding.
// ----------------------------------------------------------------------------
module btc_engine (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  btc_pkg::cfg_t                  cfg,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [btc_pkg::ACT_W-1:0] action,
  input  wire logic [btc_pkg::IDX_W-1:0] row_index,
  input  wire logic [btc_pkg::ROW_W-1:0] row_bits,
  input  wire logic [btc_pkg::OCC_W-1:0] occ,
  output logic                           res_push,
  output btc_pkg::result_t               res_data,
  output logic                           ram_wr_en,
  output logic [btc_pkg::IDX_W-1:0]      ram_wr_addr,
  output logic [btc_pkg::ROW_W-1:0]      ram_wr_data,
  output logic                           ram_rd_en,
  output logic [btc_pkg::IDX_W-1:0]      ram_rd_addr,
  input  wire logic [btc_pkg::ROW_W-1:0] ram_rd_data
);
  import btc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIVOT_RD,
    S_PIVOT_WAIT,
    S_SCAN,
    S_DONE
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] pivot;
  logic [IDX_W-1:0] scan_row;
  logic [ROW_W-1:0] pivot_row;
  logic             scan_pend;
  logic [IDX_W-1:0] wb_row;
  logic [IDX_W-1:0] wb_pivot;
  logic             wb_first;
  logic             wb_last;
  logic             read_pend;
  logic [IDX_W-1:0] read_idx;
  logic             read_in_range;
  logic             fwd_hit;
  logic [ROW_W-1:0] fwd_data;

  logic             accept;
  logic             in_range;
  logic [CNT_W-1:0] n_last;
  logic             pivot_last;
  logic             scan_last;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] read_val;
  logic             wb_hit;
  logic             wb_refl;
  logic [ROW_W-1:0] wb_data;

  assign accept     = in_valid && in_ready;
  assign in_range   = ({1'b0, row_index} < cfg.n_use);
  assign n_last     = cfg.n_use - CNT_W'(1);
  assign pivot_last = ({1'b0, pivot} == n_last);
  assign scan_last  = ({1'b0, scan_row} == n_last);
  assign in_ready   = (state == S_IDLE) &&
                      ((occ + OCC_W'(read_pend)) < OCC_W'(OUT_DEPTH));

  always_comb begin
    rd_row   = fwd_hit ? fwd_data : ram_rd_data;
    wb_hit   = rd_row[wb_pivot];
    wb_refl  = wb_last && cfg.reflexive;
    wb_data  = (rd_row & cfg.mask) | (wb_hit ? pivot_row : '0) |
               (wb_refl ? (ROW_W'(1) << wb_row) : '0);
    read_val = read_in_range ? (rd_row & cfg.mask) : '0;

    ram_rd_en   = 1'b0;
    ram_rd_addr = row_index;
    case (state)
      S_IDLE: begin
        ram_rd_en   = accept && (action == ACT_READ);
        ram_rd_addr = row_index;
      end
      S_PIVOT_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = pivot;
      end
      S_SCAN: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = scan_row;
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase

    if (scan_pend) begin
      ram_wr_en   = wb_hit || wb_first || wb_refl;
      ram_wr_addr = wb_row;
      ram_wr_data = wb_data;
    end else begin
      ram_wr_en   = (state == S_IDLE) && accept && (action == ACT_WRITE) && in_range;
      ram_wr_addr = row_index;
      ram_wr_data = row_bits & cfg.mask;
    end

    res_push = 1'b0;
    res_data = '{row_index: '0, row_bits: '0, successor_count: '0, closure_done: 1'b1};
    if (read_pend) begin
      res_push = 1'b1;
      res_data = '{row_index: read_idx, row_bits: read_val,
                   successor_count: pop_count(read_val), closure_done: 1'b0};
    end else if ((state == S_DONE) && (occ < OCC_W'(OUT_DEPTH))) begin
      res_push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    fwd_hit  <= ram_rd_en && ram_wr_en && (ram_rd_addr == ram_wr_addr);
    fwd_data <= ram_wr_data;
    read_idx      <= row_index;
    read_in_range <= in_range;
    wb_row   <= scan_row;
    wb_pivot <= pivot;
    wb_first <= (pivot == '0);
    wb_last  <= pivot_last;
    if (state == S_PIVOT_WAIT) begin
      pivot_row <= rd_row & cfg.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pivot     <= '0;
      scan_row  <= '0;
      scan_pend <= 1'b0;
      read_pend <= 1'b0;
    end else begin
      read_pend <= (state == S_IDLE) && accept && (action == ACT_READ);
      scan_pend <= (state == S_SCAN);
      case (state)
        S_IDLE: begin
          if (accept && (action == ACT_CLOSE)) begin
            pivot    <= '0;
            scan_row <= '0;
            state    <= (cfg.n_use == '0) ? S_DONE : S_PIVOT_RD;
          end
        end
        S_PIVOT_RD: begin
          state <= S_PIVOT_WAIT;
        end
        S_PIVOT_WAIT: begin
          scan_row <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_last) begin
            scan_row <= '0;
            if (pivot_last) begin
              pivot <= '0;
              state <= S_DONE;
            end else begin
              pivot <= pivot + IDX_W'(1);
              state <= S_PIVOT_RD;
            end
          end else begin
            scan_row <= scan_row + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (occ < OCC_W'(OUT_DEPTH)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) scan_pend |-> (state != S_IDLE))
    else $error("closure write-back overlaps idle traffic");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PIVOT_WAIT) |-> ($past(state) == S_PIVOT_RD))
    else $error("pivot capture without pivot read");
  assert property (@(posedge clk) disable iff (rst)
    (accept && (action == ACT_CLOSE)) |=> (state != S_IDLE))
    else $error("closure transaction did not start the sequencer");
  assert property (@(posedge clk) disable iff (rst)
    res_push |-> (occ != OCC_W'(OUT_DEPTH)))
    else $error("result pushed with no queue space");

endmodule
`default_nettype wire

FILE: hdl/bit_matrix_transitive_closure_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bit_matrix_transitive_closure_core
// Row store of a relation over up to 64 events with in-place closure.
//
//   port group  | dir | carries
//   s_*         | in  | tuser: action; tdata: row_index, row_bits
//   m_*         | out | tuser: closure_done; tdata: row_index, row_bits, count
//   cfg_*       | in  | register index and data (n_events, reflexive_mode)
//
// Row writes and reads may follow back to back while the result queue has room.
// A closure fetches each pivot row in turn, then reads every row in use and
// writes it back if it holds the pivot, on the first pass, or if reflexive.
// Reset is synchronous; the row RAM is not cleared and needs no sweep.
// A stalled master side holds up to four results before input is held off.
// ----------------------------------------------------------------------------
module bit_matrix_transitive_closure_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [btc_pkg::IN_DATA_W-1:0]     s_tdata,   // row_index, row_bits
  input  wire logic [btc_pkg::ACT_W-1:0]         s_tuser,   // action
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [btc_pkg::OUT_DATA_W-1:0]    m_tdata,   // out_row_index, out_row_bits,
                                                            // successor_count
  output logic      [0:0]                        m_tuser,   // closure_done
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [btc_pkg::REG_IDX_W-1:0]     cfg_index,
  input  wire logic [btc_pkg::CFG_W-1:0]         cfg_data
);
  import btc_pkg::*;

  cfg_t             cfg;
  logic [CNT_W-1:0] n_clamp;
  logic [OCC_W-1:0] occ;
  logic             res_push;
  result_t          res_data;
  result_t          head;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [ROW_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [ROW_W-1:0] ram_rd_data;

  assign cfg_ready = 1'b1;
  assign n_clamp   = (cfg_data > CNT_W'(MAX_EVENTS)) ? CNT_W'(MAX_EVENTS) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.n_use     <= CNT_W'(MAX_EVENTS);
      cfg.mask      <= col_mask(CNT_W'(MAX_EVENTS));
      cfg.reflexive <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_N_EVENTS: begin
          cfg.n_use <= n_clamp;
          cfg.mask  <= col_mask(n_clamp);
        end
        REG_REFLEXIVE: begin
          cfg.reflexive <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  btc_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .action      (s_tuser),
    .row_index   (s_tdata[IDX_W-1:0]),
    .row_bits    (s_tdata[IDX_W+ROW_W-1:IDX_W]),
    .occ         (occ),
    .res_push    (res_push),
    .res_data    (res_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  btc_row_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_EVENTS),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  btc_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .pop       (m_tvalid && m_tready),
    .not_empty (m_tvalid),
    .head      (head),
    .occ       (occ)
  );

  assign m_tdata = {(OUT_DATA_W - IDX_W - ROW_W - CNT_W)'(0),
                    head.successor_count, head.row_bits, head.row_index};
  assign m_tuser = head.closure_done;

endmodule
`default_nettype wire

FILE: bench/bit_matrix_transitive_closure_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_matrix_transitive_closure_core_tb
// Self-checking bench for the bit-matrix closure core. Every row is loaded
// once after reset, then a directed pass covers the extreme rows, the
// reflexive mode and event counts of zero, one and above the maximum.
// Random phases follow, each one reprogramming the event count and mode
// while the core is idle, then writing rows, mostly closing the relation
// and reading rows back; one phase only reads. A scoreboard keeps its own
// copy of the row store, predicts each read and closure result and checks
// them in order. The sender idles in bursts and the receiver stalls on
// changing patterns, with one long receiver hold-off that backs the core up.
// ----------------------------------------------------------------------------
module bit_matrix_transitive_closure_core_tb;
  import btc_pkg::*;

  localparam logic [ACT_W-1:0]     ACT_UNUSED  = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned          ITEM_GOAL   = 1400;
  localparam int unsigned          HOLD_CYCLES = 400;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  class row_closure_scoreboard_t;
    logic [ROW_W-1:0] rows [MAX_EVENTS];
    logic [CFG_W-1:0] n_events;
    logic             reflexive;
    result_t          awaited[$];
    int unsigned      errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      n_events  = 7'd64;
      reflexive = 1'b0;
      errors    = 0;
    endfunction

    function int unsigned events_used();
      return (n_events > 7'd64) ? 64 : int'(n_events);
    endfunction

    function logic [ROW_W-1:0] used_mask(int unsigned n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_N_EVENTS) begin
        n_events = data;
      end else if (idx == REG_REFLEXIVE) begin
        reflexive = data[0];
      end
    endfunction

    function void close_relation();
      int unsigned n;
      logic [ROW_W-1:0] m;
      n = events_used();
      m = used_mask(n);
      for (int i = 0; i < n; i++) rows[i] &= m;
      for (int k = 0; k < n; k++) begin
        for (int i = 0; i < n; i++) begin
          if (rows[i][k]) rows[i] |= rows[k];
        end
      end
      if (reflexive) begin
        for (int i = 0; i < n; i++) rows[i][i] = 1'b1;
      end
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                               logic [ROW_W-1:0] bits);
      int unsigned n;
      result_t r;
      n = events_used();
      r = '0;
      case (act)
        ACT_WRITE: begin
          if (idx < n) rows[idx] = bits & used_mask(n);
        end
        ACT_CLOSE: begin
          close_relation();
          r.closure_done = 1'b1;
          awaited = {awaited, r};
        end
        ACT_READ: begin
          r.row_index       = idx;
          r.row_bits        = (idx < n) ? (rows[idx] & used_mask(n)) : '0;
          r.successor_count = CNT_W'($countones(r.row_bits));
          awaited = {awaited, r};
        end
        default: ;
      endcase
    endfunction

    function void check_response(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result row %0d bits %h count %0d done %0b", $time,
                 got.row_index, got.row_bits, got.successor_count, got.closure_done);
        return;
      end
      want = awaited.pop_front();
      if (got.closure_done !== want.closure_done) begin
        errors++;
        $display("%0t: closure_done expected %0b got %0b", $time,
                 want.closure_done, got.closure_done);
      end
      if (got.row_index !== want.row_index) begin
        errors++;
        $display("%0t: row_index expected %0d got %0d", $time,
                 want.row_index, got.row_index);
      end
      if (got.row_bits !== want.row_bits) begin
        errors++;
        $display("%0t: row_bits expected %h got %h", $time, want.row_bits, got.row_bits);
      end
      if (got.successor_count !== want.successor_count) begin
        errors++;
        $display("%0t: successor_count expected %0d got %0d", $time,
                 want.successor_count, got.successor_count);
      end
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [ACT_W-1:0]      s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;

  logic                  hold_off_req   = 1'b0;
  logic                  hold_off_taken = 1'b0;
  int unsigned           hold_left      = 0;
  int unsigned           mode_left      = 0;
  rx_mode_t              rx_mode        = RX_FREE;

  row_closure_scoreboard_t sb = new();
  int unsigned           items_sent  = 0;
  int unsigned           burst_left  = 0;
  bit                    sender_eager = 1'b0;
  int unsigned           cur_n       = 64;

  bit_matrix_transitive_closure_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_reg(cfg_index, cfg_data);
      end
      if (s_tvalid && s_tready) begin
        sb.note_request(s_tuser, s_tdata[IDX_W-1:0], s_tdata[IDX_W +: ROW_W]);
      end
      if (m_tvalid && m_tready) begin
        got.row_index       = m_tdata[IDX_W-1:0];
        got.row_bits        = m_tdata[IDX_W +: ROW_W];
        got.successor_count = m_tdata[IDX_W+ROW_W +: CNT_W];
        got.closure_done    = m_tuser[0];
        sb.check_response(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_off_req && !hold_off_taken) begin
      hold_off_taken <= 1'b1;
      hold_left      <= HOLD_CYCLES;
      m_tready       <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(40, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_FREE:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= ~m_tready;
      endcase
    end
  end

  initial begin
    #10_800_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                           input logic [ROW_W-1:0] bits);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (sender_eager) begin
        gap = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(8, 30);
      end else begin
        gap = $urandom_range(0, 4);
      end
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {2'b00, bits, idx};
    do @(posedge clk); while (!s_tready);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] n, input logic refl);
    logic [REG_IDX_W-1:0] idx [3];
    logic [CFG_W-1:0]     val [3];
    idx[0] = REG_N_EVENTS;
    val[0] = n;
    idx[1] = ($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B;
    val[1] = CFG_W'($urandom);
    idx[2] = REG_REFLEXIVE;
    val[2] = {6'($urandom), refl};
    cfg_valid <= 1'b1;
    for (int w = 0; w < 3; w++) begin
      cfg_index <= idx[w];
      cfg_data  <= val[w];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_n = n;
  endtask

  function automatic logic [ROW_W-1:0] pick_row(input int unsigned nu);
    logic [ROW_W-1:0] v;
    int unsigned top;
    v   = '0;
    top = (nu == 0) ? 63 : nu - 1;
    case ($urandom_range(0, 9))
      0: v = {$urandom, $urandom};
      1: v = '1;
      default: begin
        repeat ($urandom_range(0, 3)) v[$urandom_range(0, top)] = 1'b1;
        if ($urandom_range(0, 3) == 0) v[63:32] = v[63:32] ^ $urandom;
      end
    endcase
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(input int unsigned nu);
    if (nu == 0 || $urandom_range(0, 6) == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, nu - 1));
  endfunction

  task automatic random_phase();
    int unsigned nu;
    int unsigned r;
    nu = (cur_n > 64) ? 64 : cur_n;
    repeat ($urandom_range(1, (nu < 12) ? 2 * nu + 2 : 24)) begin
      send_item(ACT_WRITE, pick_index(nu), pick_row(nu));
      if ($urandom_range(0, 19) == 0) send_item(ACT_UNUSED, IDX_W'($urandom), pick_row(64));
    end
    if ($urandom_range(0, 9) != 0) send_item(ACT_CLOSE, IDX_W'($urandom), pick_row(64));
    repeat ($urandom_range(4, 24)) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_item(ACT_WRITE, pick_index(nu), pick_row(nu));
      end else if (r < 14) begin
        send_item(ACT_UNUSED, IDX_W'($urandom), pick_row(64));
      end else if (r < 16 && nu <= 24) begin
        send_item(ACT_CLOSE, IDX_W'($urandom), pick_row(64));
      end else begin
        send_item(ACT_READ, pick_index(nu), pick_row(64));
      end
    end
  endtask

  task automatic backlog_phase();
    sender_eager = 1'b1;
    hold_off_req <= 1'b1;
    repeat (40) send_item(ACT_READ, IDX_W'($urandom), pick_row(64));
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned r;
    logic [CFG_W-1:0] n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // load every row under the full universe
    sender_eager = 1'b1;
    for (int i = 0; i < MAX_EVENTS; i++) begin
      send_item(ACT_WRITE, IDX_W'(i), {$urandom, $urandom});
    end

    sender_eager = 1'b0;
    send_item(ACT_WRITE, 6'd0, '1);
    send_item(ACT_WRITE, 6'd63, 64'h8000_0000_0000_0001);
    send_item(ACT_WRITE, 6'd1, '0);
    send_item(ACT_UNUSED, 6'd63, '1);
    send_item(ACT_READ, 6'd0, '0);
    send_item(ACT_READ, 6'd63, '0);
    send_item(ACT_READ, 6'd1, '0);
    send_item(ACT_CLOSE, 6'd0, '0);
    send_item(ACT_READ, 6'd1, '0);
    send_item(ACT_READ, 6'd63, '0);
    wait_idle();

    // three-event chain with identity added
    program_regs(7'd3, 1'b1);
    send_item(ACT_WRITE, 6'd0, 64'hF000_0000_0000_0002);
    send_item(ACT_WRITE, 6'd1, 64'h0000_0000_0000_0004);
    send_item(ACT_WRITE, 6'd2, '0);
    send_item(ACT_WRITE, 6'd40, '1);
    send_item(ACT_CLOSE, 6'd0, '0);
    send_item(ACT_READ, 6'd0, '0);
    send_item(ACT_READ, 6'd2, '0);
    send_item(ACT_READ, 6'd40, '0);
    wait_idle();

    program_regs(7'd1, 1'b0);
    send_item(ACT_WRITE, 6'd0, '1);
    send_item(ACT_CLOSE, 6'd0, '0);
    send_item(ACT_READ, 6'd0, '0);
    send_item(ACT_READ, 6'd1, '0);
    wait_idle();

    // empty universe, then a count above the maximum
    program_regs(7'd0, 1'b1);
    send_item(ACT_WRITE, 6'd0, '1);
    send_item(ACT_CLOSE, 6'd0, '0);
    send_item(ACT_READ, 6'd0, '0);
    wait_idle();
    program_regs(7'd127, 1'b0);
    send_item(ACT_READ, 6'd5, '0);
    send_item(ACT_READ, 6'd63, '0);

    phase_no = 0;
    while (items_sent < ITEM_GOAL) begin
      wait_idle();
      r = $urandom_range(0, 99);
      if (r < 60) n = CFG_W'($urandom_range(1, 12));
      else if (r < 80) n = CFG_W'($urandom_range(13, 40));
      else if (r < 88) n = CFG_W'($urandom_range(41, 64));
      else if (r < 92) n = 7'd64;
      else if (r < 96) n = 7'd0;
      else n = CFG_W'($urandom_range(65, 127));
      program_regs(n, 1'($urandom_range(0, 1)));
      sender_eager = ($urandom_range(0, 3) == 0);
      if (phase_no == 3) backlog_phase();
      else random_phase();
      phase_no++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/btc_pkg.sv
hdl/btc_row_ram.sv
hdl/btc_out_fifo.sv
hdl/btc_engine.sv
hdl/bit_matrix_transitive_closure_core.sv
bench/bit_matrix_transitive_closure_core_tb.sv
